// ----- rtl/co2rc_pkg.sv -----
// Shared types, codes and the CRC-8 step for the CO2 sensor response checker.
package co2rc_pkg;

	// Result status codes.
	localparam logic [1:0] ST_VALID     = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_CRC_ERR   = 2'd2;

	// Word index of the status word, reported when its checksum fails.
	localparam logic [1:0] WORD_STATUS  = 2'd0;

	// Byte positions inside one word.
	localparam logic [1:0] POS_HIGH     = 2'd0;
	localparam logic [1:0] POS_LOW      = 2'd1;
	localparam logic [1:0] POS_CHECK    = 2'd2;

	// Measurement word numbers.
	localparam logic [1:0] MW_CO2       = 2'd0;
	localparam logic [1:0] MW_TEMP      = 2'd1;
	localparam logic [1:0] MW_HUM       = 2'd2;

	// CRC-8 settings.
	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h31;

	// Bits of the status word that hold the ready count.
	localparam logic [15:0] READY_MASK  = 16'h07FF;

	// Conversion constants.
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	// One queued job: a finished frame outcome waiting for conversion.
	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  failed_word;
		logic [15:0] co2;
		logic [15:0] temp_word;
		logic [15:0] hum_raw;
	} job_t;

	// One CRC-8 step over a whole byte, MSB first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- rtl/co2rc_if.sv -----
// Valid/ready channel interfaces for received bytes and for checker results.
interface co2rc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface co2rc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status_code;
	logic [1:0]         failed_word;
	logic [15:0]        co2_ppm;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	modport source (output valid, output status_code, output failed_word, output co2_ppm,
		output temperature_centi, output humidity_centi, input ready);
	modport sink (input valid, input status_code, input failed_word, input co2_ppm,
		input temperature_centi, input humidity_centi, output ready);
endinterface

// ----- rtl/co2_sensor_response_checker_core.sv -----
// Top level of the CO2 sensor response checker.
//
// Usage:
//   rx  : one received sensor byte per beat, with frame_start set on the
//         first byte of the data-ready status word. frame_start always
//         restarts framing and drops any partial frame.
//   res : at most one result per frame: measurement valid, data not ready,
//         or checksum error with the index of the failing word.
// Throughput: one byte per cycle. The CRC-8 step is unrolled, so the front
//   end takes a byte every cycle while the job queue has room.
// Path: the job of the byte that closes a result goes through the queue
//   write, then the product stage, then the output register holding the
//   scaled values.
// Stall: while res is not taken, the back end holds its result and the
//   queue of QUEUE_DEPTH jobs keeps absorbing frames; rx.ready drops only
//   when that queue is full.
// Reset: all bytes are discarded until the first beat with frame_start set.
module co2_sensor_response_checker_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	co2rc_in_if.sink    rx,
	co2rc_out_if.source res
);
	import co2rc_pkg::*;

	logic  front_push;
	job_t  front_job;
	logic  q_push;
	job_t  q_din;
	logic  q_full;
	logic  q_pop;
	job_t  q_dout;
	logic  q_not_empty;

	co2rc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.queue_full (q_full),
		.push       (front_push),
		.push_job   (front_job)
	);

	co2rc_push_reg u_push (
		.push_in  (front_push),
		.job_in   (front_job),
		.job_out  (q_din),
		.push_out (q_push)
	);

	co2rc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_din),
		.full      (q_full),
		.pop       (q_pop),
		.dout      (q_dout),
		.not_empty (q_not_empty)
	);

	co2rc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_dout),
		.job_valid (q_not_empty),
		.pop       (q_pop),
		.res       (res)
	);

endmodule

// ----- rtl/co2rc_front.sv -----
// Front end: frames received bytes, runs the CRC-8 and issues one job per frame outcome.
module co2rc_front (
	input  logic               clk,
	input  logic               arst_n,
	co2rc_in_if.sink           rx,
	input  logic               queue_full,
	output logic               push,
	output co2rc_pkg::job_t    push_job
);
	import co2rc_pkg::*;

	logic       meas_q;
	logic [1:0] pos_q;
	logic [1:0] wnum_q;
	logic [7:0] crc_q;
	logic [7:0] high_q;
	logic [15:0] wval_q;
	logic [15:0] co2_q;
	logic [15:0] temp_q;
	logic       disc_q;

	logic       accept;
	logic       e_meas, e_disc;
	logic [1:0] e_pos, e_wnum;
	logic [7:0] e_crc, crc_next;
	logic       n_meas, n_disc;
	logic [1:0] n_pos, n_wnum;
	logic [7:0] n_crc, n_high;
	logic [15:0] n_wval, n_co2, n_temp;
	logic       emit;
	job_t       job_c;

	// A new byte is taken whenever the queue has room.
	assign rx.ready = !queue_full;
	assign accept   = rx.valid && rx.ready;
	assign crc_next = crc8_update(e_crc, rx.rx_byte);

	// Next state for the byte at the input.
	always_comb begin
		// A frame start restarts framing with this byte as the status high byte.
		e_meas = rx.frame_start ? 1'b0 : meas_q;
		e_disc = rx.frame_start ? 1'b0 : disc_q;
		e_pos  = rx.frame_start ? POS_HIGH : pos_q;
		e_wnum = rx.frame_start ? MW_CO2 : wnum_q;
		e_crc  = rx.frame_start ? CRC_INIT : crc_q;

		n_meas = e_meas;
		n_disc = e_disc;
		n_pos  = e_pos;
		n_wnum = e_wnum;
		n_crc  = e_crc;
		n_high = high_q;
		n_wval = wval_q;
		n_co2  = co2_q;
		n_temp = temp_q;
		emit   = 1'b0;
		job_c  = '0;

		if (!e_disc) begin
			unique case (e_pos)
				POS_HIGH: begin
					n_high = rx.rx_byte;
					n_crc  = crc_next;
					n_pos  = POS_LOW;
				end
				POS_LOW: begin
					n_wval = {high_q, rx.rx_byte};
					n_crc  = crc_next;
					n_pos  = POS_CHECK;
				end
				default: begin
					// Checksum byte closes the word.
					n_pos = POS_HIGH;
					n_crc = CRC_INIT;
					if (e_crc != rx.rx_byte) begin
						emit              = 1'b1;
						n_disc            = 1'b1;
						job_c.status      = ST_CRC_ERR;
						job_c.failed_word = e_meas ? (e_wnum + 2'd1) : WORD_STATUS;
					end else if (!e_meas) begin
						if ((wval_q & READY_MASK) == '0) begin
							emit         = 1'b1;
							n_disc       = 1'b1;
							job_c.status = ST_NOT_READY;
						end else begin
							n_meas = 1'b1;
							n_wnum = MW_CO2;
						end
					end else if (e_wnum == MW_CO2) begin
						n_co2  = wval_q;
						n_wnum = MW_TEMP;
					end else if (e_wnum == MW_TEMP) begin
						n_temp = wval_q;
						n_wnum = MW_HUM;
					end else begin
						// Humidity word completes the measurement.
						emit            = 1'b1;
						n_disc          = 1'b1;
						n_meas          = 1'b0;
						n_wnum          = MW_CO2;
						job_c.status    = ST_VALID;
						job_c.co2       = co2_q;
						job_c.temp_word = temp_q;
						job_c.hum_raw   = wval_q;
					end
				end
			endcase
		end
	end

	// Framing state registers, updated on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q <= 1'b0;
			pos_q  <= POS_HIGH;
			wnum_q <= MW_CO2;
			crc_q  <= CRC_INIT;
			high_q <= '0;
			wval_q <= '0;
			co2_q  <= '0;
			temp_q <= '0;
			disc_q <= 1'b1;
		end else if (accept) begin
			meas_q <= n_meas;
			pos_q  <= n_pos;
			wnum_q <= n_wnum;
			crc_q  <= n_crc;
			high_q <= n_high;
			wval_q <= n_wval;
			co2_q  <= n_co2;
			temp_q <= n_temp;
			disc_q <= n_disc;
		end
	end

	assign push     = accept && emit;
	assign push_job = job_c;

	// Every result is followed by discarding until the next frame start.
	a_disc_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> disc_q)
		else $error("front: not discarding after a result");

	// A result leaves the CRC at its initial value and the position at the high byte.
	a_crc_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (crc_q == CRC_INIT) && (pos_q == POS_HIGH))
		else $error("front: CRC not reinitialized after a result");

endmodule

// ----- rtl/co2rc_queue.sv -----
// Short job queue that decouples the front end from the conversion back end.
module co2rc_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  co2rc_pkg::job_t din,
	output logic            full,
	input  logic            pop,
	output co2rc_pkg::job_t dout,
	output logic            not_empty
);
	import co2rc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = slots_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue: push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue: pop while empty");

endmodule

// ----- rtl/co2rc_back.sv -----
// Back end: scales temperature and humidity in two stages and holds the result beat.
module co2rc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  co2rc_pkg::job_t job,
	input  logic            job_valid,
	output logic            pop,
	co2rc_out_if.source     res
);
	import co2rc_pkg::*;

	logic        v_s1;
	logic [1:0]  status_s1;
	logic [1:0]  fw_s1;
	logic [15:0] co2_s1;
	logic [30:0] tprod_s1;
	logic [29:0] hprod_s1;

	logic               v_s2;
	logic [1:0]         status_s2;
	logic [1:0]         fw_s2;
	logic [15:0]        co2_s2;
	logic signed [14:0] temp_s2;
	logic [13:0]        hum_s2;

	logic        load_s2;
	logic        load_s1;
	logic [14:0] t_q0, t_quo;
	logic [16:0] t_rem;
	logic [13:0] h_q0, h_quo;
	logic [16:0] h_rem;
	logic [15:0] t_cent;
	logic        is_valid;

	// Stage handshakes: each stage loads when it is empty or drains this cycle.
	assign load_s2 = v_s1 && (!v_s2 || res.ready);
	assign load_s1 = job_valid && (!v_s1 || load_s2);
	assign pop     = load_s1;

	// Stage 1: scale products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (load_s2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			status_s1 <= job.status;
			fw_s1     <= job.failed_word;
			co2_s1    <= job.co2;
			tprod_s1  <= 31'(job.temp_word) * 31'(TEMP_SCALE);
			hprod_s1  <= 30'(job.hum_raw) * 30'(HUM_SCALE);
		end
	end

	// Divide by 65535: the quotient estimate p>>16 is low by at most one,
	// and the remainder estimate (p mod 65536) + (p>>16) stays below 2*65535.
	always_comb begin
		t_q0   = tprod_s1[30:16];
		t_rem  = {1'b0, tprod_s1[15:0]} + 17'(t_q0);
		t_quo  = t_q0 + 15'(t_rem >= FULL_SCALE);
		h_q0   = hprod_s1[29:16];
		h_rem  = {1'b0, hprod_s1[15:0]} + 17'(h_q0);
		h_quo  = h_q0 + 14'(h_rem >= FULL_SCALE);
		t_cent = 16'(t_quo) - TEMP_OFFSET;
		is_valid = (status_s1 == ST_VALID);
	end

	// Stage 2: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= 1'b1;
		end else if (res.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			status_s2 <= status_s1;
			fw_s2     <= fw_s1;
			co2_s2    <= is_valid ? co2_s1 : '0;
			temp_s2   <= is_valid ? signed'(t_cent[14:0]) : '0;
			hum_s2    <= is_valid ? h_quo : '0;
		end
	end

	assign res.valid             = v_s2;
	assign res.status_code       = status_s2;
	assign res.failed_word       = fw_s2;
	assign res.co2_ppm           = co2_s2;
	assign res.temperature_centi = temp_s2;
	assign res.humidity_centi    = hum_s2;

	// Non-measurement results carry zero data.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (status_s2 != ST_VALID)) |->
		((co2_s2 == '0) && (temp_s2 == '0) && (hum_s2 == '0)))
		else $error("back: data fields not cleared");

	// Only checksum errors name a failing word.
	a_fw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (status_s2 != ST_CRC_ERR)) |-> (fw_s2 == WORD_STATUS))
		else $error("back: failed word set without checksum error");

endmodule

// ----- rtl/co2rc_core_top_note.sv -----
// Boundary between front end and queue that normalizes the failed word field of each job.
module co2rc_push_reg (
	input  logic            push_in,
	input  co2rc_pkg::job_t job_in,
	output co2rc_pkg::job_t job_out,
	output logic            push_out
);
	import co2rc_pkg::*;

	// Passes the push straight on; the job is reformatted so that failed_word
	// is only kept for checksum errors.
	always_comb begin
		job_out = job_in;
		if (job_in.status != ST_CRC_ERR) begin
			job_out.failed_word = WORD_STATUS;
		end
	end

	assign push_out = push_in;

endmodule

// ----- tb/co2_sensor_response_checker_core_tb.sv -----
// Testbench for the CO2 sensor response checker: directed and random frames, decoder-checked.
module co2_sensor_response_checker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import co2rc_pkg::*;

	// Codes that the package does not name.
	localparam logic [1:0] WORD_CO2  = 2'd1;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         failed_word;
		logic [15:0]        co2;
		logic signed [14:0] temp;
		logic [13:0]        hum;
	} reading_t;

	// One planned byte beat, with a hand-written reading where one is known.
	typedef struct {
		logic [7:0] b;
		bit         fs;
		bit         known;
		reading_t   want;
	} rx_beat_t;

	logic clk;
	logic arst_n;

	co2rc_in_if  byte_ch ();
	co2rc_out_if result_ch ();

	co2_sensor_response_checker_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (byte_ch),
		.res    (result_ch)
	);

	rx_beat_t rx_plan[$];
	reading_t pending_readings[$];
	int       beats_sent = 0;
	int       beats_taken = 0;
	int       phase = 0;
	int       errors = 0;

	// Decoder state, at its reset values.
	bit          dec_in_meas = 1'b0;
	logic [1:0]  dec_pos = POS_HIGH;
	logic [1:0]  dec_word_num = MW_CO2;
	logic [7:0]  dec_crc = CRC_INIT;
	logic [7:0]  dec_high = 8'h00;
	logic [15:0] dec_word = 16'h0000;
	logic [15:0] dec_co2 = 16'h0000;
	logic [15:0] dec_temp = 16'h0000;
	bit          dec_drop = 1'b1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(12ns * 300000);
		$display("FAIL");
		$finish;
	end

	// CRC-8 over one byte, polynomial 0x31, MSB first.
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] v;
		v = acc ^ d;
		repeat (8) v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		return v;
	endfunction

	// Decodes one accepted byte; returns 1 when the byte closes a frame with a reading.
	function automatic bit sensor_decode(input logic [7:0] b, input bit fs, output reading_t r);
		int unsigned t_scaled;
		int unsigned h_scaled;
		int          t_signed;
		r = '0;
		if (fs) begin
			dec_in_meas = 1'b0;
			dec_pos = POS_HIGH;
			dec_word_num = MW_CO2;
			dec_crc = CRC_INIT;
			dec_drop = 1'b0;
		end else if (dec_drop) begin
			return 1'b0;
		end

		if (dec_pos == POS_HIGH) begin
			dec_high = b;
			dec_crc = crc8_step(dec_crc, b);
			dec_pos = POS_LOW;
			return 1'b0;
		end
		if (dec_pos == POS_LOW) begin
			dec_word = {dec_high, b};
			dec_crc = crc8_step(dec_crc, b);
			dec_pos = POS_CHECK;
			return 1'b0;
		end

		// Checksum byte closes the word.
		dec_pos = POS_HIGH;
		if (dec_crc != b) begin
			r.status = ST_CRC_ERR;
			r.failed_word = dec_in_meas ? dec_word_num + 2'd1 : WORD_STATUS;
			dec_crc = CRC_INIT;
			dec_drop = 1'b1;
			return 1'b1;
		end
		dec_crc = CRC_INIT;

		if (!dec_in_meas) begin
			if ((dec_word & READY_MASK) == 16'h0000) begin
				r.status = ST_NOT_READY;
				dec_drop = 1'b1;
				return 1'b1;
			end
			dec_in_meas = 1'b1;
			dec_word_num = MW_CO2;
			return 1'b0;
		end
		if (dec_word_num == MW_CO2) begin
			dec_co2 = dec_word;
			dec_word_num = MW_TEMP;
			return 1'b0;
		end
		if (dec_word_num == MW_TEMP) begin
			dec_temp = dec_word;
			dec_word_num = MW_HUM;
			return 1'b0;
		end

		// Humidity word: scale both readings and finish the frame.
		t_scaled = (32'd17500 * dec_temp) / 32'd65535;
		h_scaled = (32'd10000 * dec_word) / 32'd65535;
		t_signed = int'(t_scaled) - 4500;
		r.status = ST_VALID;
		r.co2 = dec_co2;
		r.temp = t_signed[14:0];
		r.hum = h_scaled[13:0];
		dec_drop = 1'b1;
		dec_in_meas = 1'b0;
		dec_word_num = MW_CO2;
		return 1'b1;
	endfunction

	// Appends the first cut bytes of a frame of four words; bad[k] corrupts the CRC of word k.
	task automatic add_frame(input logic [63:0] words, input logic [3:0] bad, input int cut);
		logic [7:0]  fr [12];
		logic [15:0] w;
		logic [7:0]  flip;
		for (int k = 0; k < 4; k++) begin
			w = words[63 - 16 * k -: 16];
			flip = 8'h01 << $urandom_range(7);
			fr[3 * k] = w[15:8];
			fr[3 * k + 1] = w[7:0];
			fr[3 * k + 2] = crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]) ^
				(bad[k] ? flip : 8'h00);
		end
		for (int j = 0; j < cut; j++) begin
			rx_plan.push_back('{b: fr[j], fs: (j == 0), known: 1'b0, want: '0});
		end
	endtask

	task automatic mark_last(input reading_t r);
		rx_plan[rx_plan.size() - 1].known = 1'b1;
		rx_plan[rx_plan.size() - 1].want = r;
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Stimulus plan and byte driver.
	initial begin
		int          frames;
		int          total;
		int          idle_pct;
		int          n;
		logic [15:0] status_word;
		logic [3:0]  bad;

		byte_ch.valid <= 1'b0;
		byte_ch.rx_byte <= 8'h00;
		byte_ch.frame_start <= 1'b0;

		// A stray byte before any frame start is ignored.
		rx_plan.push_back('{b: 8'hA5, fs: 1'b0, known: 1'b0, want: '0});
		// Status word with a zero count, then one with only the upper bits set.
		add_frame({16'h0000, 48'h0}, 4'b0000, 3);
		mark_last('{ST_NOT_READY, WORD_STATUS, 16'd0, 15'sd0, 14'd0});
		add_frame({16'hF800, 48'h0}, 4'b0000, 3);
		mark_last('{ST_NOT_READY, WORD_STATUS, 16'd0, 15'sd0, 14'd0});
		// Broken status checksum.
		add_frame({16'hBEEF, 48'h0}, 4'b0001, 3);
		mark_last('{ST_CRC_ERR, WORD_STATUS, 16'd0, 15'sd0, 14'd0});
		// Full-scale measurement.
		add_frame({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 4'b0000, 12);
		mark_last('{ST_VALID, WORD_STATUS, 16'hFFFF, 15'sd13000, 14'd10000});
		// Broken CO2 checksum.
		add_frame({16'h0001, 16'h1234, 32'h0}, 4'b0010, 6);
		mark_last('{ST_CRC_ERR, WORD_CO2, 16'd0, 15'sd0, 14'd0});

		// Random part: mostly well-formed frames, some truncated, some noise.
		frames = 0;
		n = rx_plan.size();
		while (rx_plan.size() < n + 370 || frames < 20) begin
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 4)) begin
					rx_plan.push_back('{b: 8'($urandom), fs: ($urandom_range(3) == 0),
						known: 1'b0, want: '0});
				end
			end else begin
				frames++;
				status_word = 16'($urandom);
				if ($urandom_range(9) == 0) begin
					status_word[10:0] = 11'h000;
				end
				bad = 4'b0000;
				for (int k = 0; k < 4; k++) begin
					bad[k] = ($urandom_range(99) < 5);
				end
				add_frame({status_word, 16'($urandom), pick_raw(), pick_raw()}, bad,
					($urandom_range(9) == 0) ? $urandom_range(1, 11) : 12);
			end
		end

		total = rx_plan.size();
		while (!arst_n) @(posedge clk);

		// Once the previous beat has gone, offer the next one or idle, at random by phase.
		while (beats_taken < total) begin
			@(posedge clk);
			idle_pct = (phase == 0) ? 37 : (phase == 1) ? 60 : 0;
			if (!byte_ch.valid || byte_ch.ready) begin
				if (beats_sent < total && $urandom_range(99) >= idle_pct) begin
					byte_ch.valid <= 1'b1;
					byte_ch.rx_byte <= rx_plan[beats_sent].b;
					byte_ch.frame_start <= rx_plan[beats_sent].fs;
					beats_sent++;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
			phase <= (beats_sent < total / 3) ? 0 : (beats_sent < 2 * total / 3) ? 1 : 2;
		end

		// Drain the results, then give the block time to show anything extra.
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Result side ready, stalling by phase.
	initial begin
		int stall_pct;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall_pct = (phase == 0) ? 60 : (phase == 1) ? 37 : 0;
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void check_field(input string name, input int exp_v, input int got_v,
		input bit differs);
		if (differs) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	// Predict on every accepted byte beat, check every accepted result beat.
	always @(posedge clk) begin : monitor
		reading_t exp_r;
		reading_t got_r;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				if (sensor_decode(byte_ch.rx_byte, byte_ch.frame_start, exp_r)) begin
					pending_readings.push_back(rx_plan[beats_taken].known ?
						rx_plan[beats_taken].want : exp_r);
				end
				beats_taken <= beats_taken + 1;
			end
			if (result_ch.valid && result_ch.ready) begin
				got_r.status = result_ch.status_code;
				got_r.failed_word = result_ch.failed_word;
				got_r.co2 = result_ch.co2_ppm;
				got_r.temp = result_ch.temperature_centi;
				got_r.hum = result_ch.humidity_centi;
				if (pending_readings.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d", $time, got_r.status);
					errors++;
				end else begin
					exp_r = pending_readings.pop_front();
					check_field("status_code", exp_r.status, got_r.status,
						got_r.status !== exp_r.status);
					check_field("word index", exp_r.failed_word, got_r.failed_word,
						got_r.failed_word !== exp_r.failed_word);
					check_field("co2_ppm", exp_r.co2, got_r.co2, got_r.co2 !== exp_r.co2);
					check_field("temperature_centi", exp_r.temp, got_r.temp,
						got_r.temp !== exp_r.temp);
					check_field("humidity_centi", exp_r.hum, got_r.hum,
						got_r.hum !== exp_r.hum);
				end
			end
		end
	end

endmodule

// ----- sim.f -----
rtl/co2rc_pkg.sv
rtl/co2rc_if.sv
rtl/co2rc_front.sv
rtl/co2rc_queue.sv
rtl/co2rc_back.sv
rtl/co2rc_core_top_note.sv
rtl/co2_sensor_response_checker_core.sv
tb/co2_sensor_response_checker_core_tb.sv
